FILE: src/jlgr_pkg.sv
`default_nettype none

package jlgr_pkg;

	localparam int CFG_AW = 2;
	localparam int CFG_DW = 16;
	localparam int VAL_W  = 16;

	localparam logic [CFG_AW-1:0] CFG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_SWEEP_COUNT = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_TOP_VALUE   = 2'd2;

	localparam logic [5:0]       GRID_WIDTH_RST  = 6'd8;
	localparam logic [VAL_W-1:0] SWEEP_COUNT_RST = 16'd1;
	localparam logic [VAL_W-1:0] TOP_VALUE_RST   = 16'd20480;
	localparam logic [VAL_W-1:0] ONE_Q412        = 16'd4096;

	localparam logic [1:0] CMD_INIT = 2'd0;
	localparam logic [1:0] CMD_RUN  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_SWEEP,
		ST_DRAIN,
		ST_READ,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic accept;
		logic fill;
		logic fill_top;
		logic init_regs;
		logic issue;
		logic commit;
		logic out_load;
	} ctrl_t;

	typedef struct packed {
		logic scan_last;
		logic pipe_empty;
		logic last_sweep;
		logic zero_sweeps;
		logic out_busy;
	} stat_t;

endpackage

`default_nettype wire

FILE: src/jlgr_ram.sv
`default_nettype none

module jlgr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: src/jlgr_ctrl.sv
`default_nettype none

module jlgr_ctrl
	import jlgr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_valid,
	input  wire logic [1:0] cmd,
	output logic            s_ready,
	input  wire stat_t      stat,
	output ctrl_t           ctrl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.scan_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_valid) begin
					unique case (cmd)
						CMD_INIT: state_d = ST_FILL;
						CMD_RUN:  state_d = stat.zero_sweeps ? ST_RESP : ST_SWEEP;
						CMD_READ: state_d = ST_READ;
						default:  state_d = ST_RESP;
					endcase
				end
			end
			ST_FILL: begin
				if (stat.scan_last) state_d = ST_RESP;
			end
			ST_SWEEP: begin
				if (stat.scan_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (stat.pipe_empty) state_d = stat.last_sweep ? ST_RESP : ST_SWEEP;
			end
			ST_READ: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!stat.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl    = '0;
		s_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ctrl.fill = 1'b1;
			end
			ST_IDLE: begin
				s_ready     = 1'b1;
				ctrl.accept = s_valid;
			end
			ST_FILL: begin
				ctrl.fill      = 1'b1;
				ctrl.fill_top  = 1'b1;
				ctrl.init_regs = stat.scan_last;
			end
			ST_SWEEP: begin
				ctrl.issue = 1'b1;
			end
			ST_DRAIN: begin
				ctrl.commit = stat.pipe_empty;
			end
			ST_READ: begin
			end
			ST_RESP: begin
				ctrl.out_load = !stat.out_busy;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: src/jlgr_datapath.sv
`default_nettype none

module jlgr_datapath
	import jlgr_pkg::*;
#(
	parameter int MAX_WIDTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [CFG_DW-1:0] cfg_wdata,
	input  wire logic [1:0]        cmd,
	input  wire logic [5:0]        cell_row,
	input  wire logic [4:0]        cell_col,
	input  wire ctrl_t             ctrl,
	output stat_t                  stat,
	output logic                   m_valid,
	input  wire logic              m_ready,
	output logic [3*VAL_W-1:0]     m_data
);

	localparam int DEPTH = (MAX_WIDTH + 1) * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int KW    = $clog2((MAX_WIDTH + 2) * MAX_WIDTH);
	localparam int RW    = $clog2(MAX_WIDTH + 2);
	localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int TAPS  = 2 * MAX_WIDTH + 1;

	logic [5:0]       grid_width_q;
	logic [VAL_W-1:0] sweep_count_q;
	logic [VAL_W-1:0] top_value_q;
	logic [6:0]       w;

	logic             cur_q;
	logic [VAL_W-1:0] last_change_q;
	logic [VAL_W-1:0] last_sweeps_q;
	logic [VAL_W-1:0] worst_q;
	logic [VAL_W-1:0] sweep_cnt_q;

	logic [1:0] cmd_q;
	logic [5:0] row_q;
	logic [4:0] col_q;

	logic [KW-1:0] k_q;
	logic [RW-1:0] rr_q;
	logic [CW-1:0] cc_q;

	logic          v_s1, v_s2, v_s3;
	logic [KW-1:0] k_s1, k_s2;
	logic [RW-1:0] rr_s1, rr_s2;
	logic [CW-1:0] cc_s1, cc_s2;
	logic [AW-1:0] addr_s3;
	logic [VAL_W-1:0] nv_s3, old_s3;

	logic [VAL_W-1:0] line_q [TAPS];

	logic             out_valid_q;
	logic [VAL_W-1:0] out_cell_q, out_change_q, out_sweeps_q;

	logic             scan_last;
	logic [AW-1:0]    raddr, waddr, sweep_addr, rd_addr;
	logic [31:0]      rd_addr_full, center_full;
	logic             in_range;
	logic [VAL_W-1:0] rdata_a, rdata_b, src_data;
	logic [VAL_W-1:0] fill_value, wdata;
	logic             we_a, we_b;
	logic [17:0]      sum;
	logic [VAL_W-1:0] old_v, nv;
	logic             in_area, interior;
	logic [VAL_W-1:0] diff;

	always_comb begin
		if (grid_width_q == 6'd0) begin
			w = 7'd1;
		end else if (32'(grid_width_q) > MAX_WIDTH) begin
			w = 7'(MAX_WIDTH);
		end else begin
			w = {1'b0, grid_width_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_WIDTH_RST;
			sweep_count_q <= SWEEP_COUNT_RST;
			top_value_q   <= TOP_VALUE_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_GRID_WIDTH:  grid_width_q  <= cfg_wdata[5:0];
				CFG_SWEEP_COUNT: sweep_count_q <= cfg_wdata;
				CFG_TOP_VALUE:   top_value_q   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			cmd_q <= cmd;
			row_q <= cell_row;
			col_q <= cell_col;
		end
	end

	// scan counter shared by the fill pass and the sweep read walk
	always_comb begin
		if (ctrl.fill) begin
			scan_last = 32'(k_q) == DEPTH - 1;
		end else begin
			scan_last = (32'(rr_q) == 32'(w) + 32'd1) && (32'(cc_q) == MAX_WIDTH - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= '0;
			rr_q <= '0;
			cc_q <= '0;
		end else if (ctrl.fill || ctrl.issue) begin
			if (scan_last) begin
				k_q  <= '0;
				rr_q <= '0;
				cc_q <= '0;
			end else begin
				k_q <= k_q + 1'b1;
				if (32'(cc_q) == MAX_WIDTH - 1) begin
					cc_q <= '0;
					rr_q <= rr_q + 1'b1;
				end else begin
					cc_q <= cc_q + 1'b1;
				end
			end
		end
	end

	assign sweep_addr   = (32'(k_q) < DEPTH) ? k_q[AW-1:0] : '0;
	assign rd_addr_full = 32'(row_q) * MAX_WIDTH + 32'(col_q);
	assign in_range     = (32'(row_q) <= 32'(w)) && (32'(col_q) < 32'(w));
	assign rd_addr      = in_range ? rd_addr_full[AW-1:0] : '0;
	assign raddr        = ctrl.issue ? sweep_addr : rd_addr;

	assign fill_value = (ctrl.fill_top && rr_q == '0 && 32'(cc_q) < 32'(w)) ?
		top_value_q : '0;
	assign waddr = ctrl.fill ? k_q[AW-1:0] : addr_s3;
	assign wdata = ctrl.fill ? fill_value : nv_s3;
	assign we_a  = ctrl.fill || (v_s3 && cur_q);
	assign we_b  = ctrl.fill || (v_s3 && !cur_q);

	jlgr_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_a)
	);

	jlgr_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_b)
	);

	assign src_data = cur_q ? rdata_b : rdata_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= ctrl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && in_area;
		end
	end

	always_ff @(posedge clk) begin
		k_s1  <= k_q;
		rr_s1 <= rr_q;
		cc_s1 <= cc_q;
		k_s2  <= k_s1;
		rr_s2 <= rr_s1;
		cc_s2 <= cc_s1;
		addr_s3 <= center_full[AW-1:0];
		nv_s3   <= nv;
		old_s3  <= old_v;
	end

	// two rows plus one of the source grid, center cell at the middle tap
	always_ff @(posedge clk) begin
		if (v_s1) begin
			line_q[0] <= src_data;
			for (int i = 1; i < TAPS; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign sum = 18'(line_q[0]) + 18'(line_q[2*MAX_WIDTH])
		+ 18'(line_q[MAX_WIDTH-1]) + 18'(line_q[MAX_WIDTH+1]);
	assign old_v = line_q[MAX_WIDTH];
	assign in_area  = (rr_s2 != '0) && (32'(cc_s2) < 32'(w));
	assign interior = (32'(rr_s2) != 32'd1) && (32'(rr_s2) != 32'(w) + 32'd1)
		&& (cc_s2 != '0) && (32'(cc_s2) != 32'(w) - 32'd1);
	assign nv = interior ? sum[17:2] : old_v;
	assign center_full = 32'(k_s2) - 32'(MAX_WIDTH);

	assign diff = (nv_s3 > old_s3) ? (nv_s3 - old_s3) : (old_s3 - nv_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q         <= 1'b0;
			last_change_q <= ONE_Q412;
			last_sweeps_q <= '0;
			worst_q       <= '0;
			sweep_cnt_q   <= '0;
		end else begin
			if (ctrl.accept && cmd == CMD_RUN) begin
				last_sweeps_q <= sweep_count_q;
			end
			if (ctrl.init_regs) begin
				cur_q         <= 1'b0;
				last_change_q <= ONE_Q412;
				last_sweeps_q <= '0;
				worst_q       <= '0;
			end else if (ctrl.commit) begin
				cur_q         <= !cur_q;
				last_change_q <= worst_q;
				worst_q       <= '0;
				sweep_cnt_q   <= stat.last_sweep ? '0 : sweep_cnt_q + 1'b1;
			end else if (v_s3 && diff > worst_q) begin
				worst_q <= diff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			out_cell_q   <= (cmd_q == CMD_READ && in_range) ? src_data : '0;
			out_change_q <= last_change_q;
			out_sweeps_q <= last_sweeps_q;
		end
	end

	assign m_valid = out_valid_q;
	assign m_data  = {out_sweeps_q, out_change_q, out_cell_q};

	always_comb begin
		stat.scan_last   = scan_last;
		stat.pipe_empty  = !v_s1 && !v_s2 && !v_s3;
		stat.last_sweep  = (17'(sweep_cnt_q) + 17'd1) == 17'(sweep_count_q);
		stat.zero_sweeps = sweep_count_q == '0;
		stat.out_busy    = out_valid_q && !m_ready;
	end

endmodule

`default_nettype wire

FILE: src/jacobi_laplace_grid_relaxer.sv
`default_nettype none

// Jacobi relaxation of a 2D Laplace grid in unsigned Q4.12, held in two grid memories of
// (MAX_WIDTH+1)*MAX_WIDTH cells. Each accepted command gives one result transfer. After
// reset a clearing pass writes zero to every cell, during which no command is taken.
// Initialize walks the whole grid memory one cell a cycle. Each sweep of Run reads the
// (w+2)*MAX_WIDTH cells of a width w in use through the single read port of the source
// grid, feeding a two-row window one cell a cycle, then drains the pipeline. A new
// command is taken while the previous result waits at the output.

module jacobi_laplace_grid_relaxer
	import jlgr_pkg::*;
#(
	parameter int MAX_WIDTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [CFG_DW-1:0] cfg_wdata,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [15:0]       s_axis_tdata,  // cmd[1:0], cell_row[7:2], cell_col[12:8]
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [47:0]            m_axis_tdata   // cell_value[15:0], max_change[31:16],
	                                              // sweeps_done[47:32]
);

	ctrl_t ctrl;
	stat_t stat;

	jlgr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.cmd     (s_axis_tdata[1:0]),
		.s_ready (s_axis_tready),
		.stat    (stat),
		.ctrl    (ctrl)
	);

	jlgr_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cmd       (s_axis_tdata[1:0]),
		.cell_row  (s_axis_tdata[7:2]),
		.cell_col  (s_axis_tdata[12:8]),
		.ctrl      (ctrl),
		.stat      (stat),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.m_data    (m_axis_tdata)
	);

endmodule

`default_nettype wire
